// ----- design/emt_pkg.sv -----
// ----------------------------------------------------------------------------
// emt_pkg
// Shared types and constants for the expiring miss table.
// ----------------------------------------------------------------------------
package emt_pkg;

  localparam int DEPTH      = 8;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int ID_W       = 32;
  localparam int TIME_W     = 64;
  localparam int LIFE_W     = 32;
  localparam int FUNC_W     = 2;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(3000);

  typedef enum logic [FUNC_W-1:0] {
    OP_QUERY    = 2'd0,
    OP_REMEMBER = 2'd1,
    OP_FORGET   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the input item, restart the scan
    logic scan;   // visit one entry
    logic fin;    // commit remember write, load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;    // entry being visited is the last one
    logic out_blocked;  // result register full and not taken this cycle
  } sts_t;

endpackage

// ----- design/emt_ctrl.sv -----
// ----------------------------------------------------------------------------
// emt_ctrl
// Sequencer: accept, scan every entry, finish and hand over the result.
// ----------------------------------------------------------------------------
module emt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  emt_pkg::sts_t sts,
  output emt_pkg::cmd_t cmd
);
  import emt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // no item taken while reset is held
        in_ready = rst_n;
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the result register has room
        if (!sts.out_blocked) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/emt_dpath.sv -----
// ----------------------------------------------------------------------------
// emt_dpath
// Entry table, scan compare, slot choice, lifetime register, result register.
// ----------------------------------------------------------------------------
module emt_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  emt_pkg::cmd_t               cmd,
  output emt_pkg::sts_t               sts,
  input  logic [emt_pkg::FUNC_W-1:0]  in_func,
  input  logic [emt_pkg::ID_W-1:0]    in_ident,
  input  logic [emt_pkg::TIME_W-1:0]  in_now_time,
  input  logic                        cfg_we,
  input  logic [emt_pkg::LIFE_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit
);
  import emt_pkg::*;

  logic [ID_W-1:0]   ent_ident_r  [DEPTH];
  logic [TIME_W-1:0] ent_expiry_r [DEPTH];

  logic [LIFE_W-1:0] lifetime_r;
  logic [FUNC_W-1:0] func_r;
  logic [ID_W-1:0]   ident_r;
  logic [TIME_W-1:0] now_r;
  logic [IDX_W-1:0]  idx_r;
  logic              hit_r;
  logic              match_found_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic              out_valid_r;
  logic              out_hit_r;

  logic [ID_W-1:0]   rd_ident;
  logic [TIME_W-1:0] rd_expiry;
  logic              id_eq;
  logic              live;
  logic              is_query;
  logic              is_remember;
  logic              is_forget;
  logic              forget_wr;
  logic              remember_wr;
  logic [IDX_W-1:0]  pick;
  logic [TIME_W-1:0] new_expiry;

  assign rd_ident    = ent_ident_r[idx_r];
  assign rd_expiry   = ent_expiry_r[idx_r];
  assign id_eq       = (rd_ident == ident_r);
  assign live        = (now_r < rd_expiry);
  assign is_query    = (func_r == OP_QUERY);
  assign is_remember = (func_r == OP_REMEMBER);
  assign is_forget   = (func_r == OP_FORGET);
  assign forget_wr   = cmd.scan && is_forget && id_eq;
  assign remember_wr = cmd.fin && is_remember;
  assign new_expiry  = now_r + TIME_W'(lifetime_r);

  // same ident first, then first empty or expired, else ident mod depth
  always_comb begin
    if (match_found_r) begin
      pick = match_idx_r;
    end else if (free_found_r) begin
      pick = free_idx_r;
    end else begin
      pick = IDX_W'(ident_r % DEPTH);
    end
  end

  assign sts.scan_last   = (idx_r == IDX_W'(DEPTH - 1));
  assign sts.out_blocked = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= LIFETIME_RESET;
    end else if (cfg_we) begin
      lifetime_r <= cfg_wdata;
    end
  end

  // table: cleared at reset, one write per cycle at most
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        ent_ident_r[k]  <= '0;
        ent_expiry_r[k] <= '0;
      end
    end else if (forget_wr) begin
      ent_ident_r[idx_r]  <= '0;
      ent_expiry_r[idx_r] <= '0;
    end else if (remember_wr) begin
      ent_ident_r[pick]  <= ident_r;
      ent_expiry_r[pick] <= new_expiry;
    end
  end

  // item capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r        <= in_func;
      ident_r       <= in_ident;
      now_r         <= in_now_time;
      idx_r         <= '0;
      hit_r         <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + IDX_W'(1);
      if (id_eq && live) begin
        hit_r <= 1'b1;
      end
      if (id_eq && !match_found_r) begin
        match_found_r <= 1'b1;
        match_idx_r   <= idx_r;
      end
      if ((rd_ident == '0 || !live) && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_hit_r <= is_query && hit_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

// ----- design/expiring_miss_table.sv -----
// ----------------------------------------------------------------------------
// expiring_miss_table
// Fully associative table of recently missed identifiers with expiry times.
// ----------------------------------------------------------------------------
// Timing: the result follows the scan of every entry (DEPTH = 8) and the finish
//   step that loads the result register. A new item is taken only once the
//   previous one is finished, since the single table read port is walked by
//   the scan one entry per cycle.
// Reset (rst_n low, synchronous): table cleared to zeros, lifetime back to
//   3000 ms, no result pending; ready for an item as soon as rst_n is high.
module expiring_miss_table (
  input  logic                        clk,
  input  logic                        rst_n,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [emt_pkg::FUNC_W-1:0]  in_func,
  input  logic [emt_pkg::ID_W-1:0]    in_ident,
  input  logic [emt_pkg::TIME_W-1:0]  in_now_time,
  // result items
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_hit,
  // lifetime register
  input  logic                        cfg_we,
  input  logic [emt_pkg::LIFE_W-1:0]  cfg_wdata
);
  import emt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer. Idle takes an item; the scan visits every entry in turn:
  //   query    - any matching live entry sets the hit flag
  //   remember - notes the first matching slot and the first empty/expired one
  //   forget   - zeroes each matching entry as it is visited
  // The finish step writes a remembered entry and loads the result register;
  // it waits there only while a previous result is still held by the sink.
  emt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, compare logic, expiry adder (wraps at 64 bits) and result register.
  emt_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_func     (in_func),
    .in_ident    (in_ident),
    .in_now_time (in_now_time),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_hit     (out_hit)
  );

endmodule
